// ----- rtl/core/fitr_pkg.sv -----
// Shared types and constants for the frame id translation ring.
`default_nettype none
package fitr_pkg;

	localparam int RING_DEPTH_DEF = 64;
	localparam int ID_W           = 64;

	localparam logic REQ_FWD = 1'b0;
	localparam logic REQ_REV = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FWD_SCAN,
		ST_REV_CHECK,
		ST_REV_READ,
		ST_REV_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/fitr_ring_mem.sv -----
// Caller id ring storage: one write port, one read port, registered read data.
`default_nettype none
module fitr_ring_mem
	import fitr_pkg::*;
#(
	parameter int DEPTH = RING_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire mem_ctl_t        ctl,
	input  wire logic [AW-1:0]   rd_addr,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire logic [ID_W-1:0] wr_data,
	output logic      [ID_W-1:0] rd_data
);

	logic [ID_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/fitr_seq.sv -----
// Request sequencer: device id counter, write slot, ring scan and reverse lookup.
`default_nettype none
module fitr_seq
	import fitr_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int SW         = $clog2(RING_DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            req_type,
	input  wire logic [ID_W-1:0] frame_id,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output logic      [ID_W-1:0] res_id,
	output logic                 res_hit,
	output mem_ctl_t             mem_ctl,
	output logic      [SW-1:0]   rd_addr,
	output logic      [SW-1:0]   wr_addr,
	output logic      [ID_W-1:0] wr_data,
	input  wire logic [ID_W-1:0] rd_data
);

	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(RING_DEPTH);
	localparam logic [SW:0]   DEPTH_M1  = (SW + 1)'(RING_DEPTH - 1);
	localparam logic [SW:0]   DEPTH_X   = (SW + 1)'(RING_DEPTH);
	localparam logic [ID_W-1:0] DEPTH_ID = ID_W'(RING_DEPTH);

	state_t state_q, state_d;

	logic [ID_W-1:0] next_q;
	logic [SW-1:0]   ws_q;
	logic [ID_W-1:0] id_q;
	logic [CW-1:0]   limit_q;
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   ptr_q;
	logic            chk_v_s1;
	logic [SW-1:0]   age_s1;
	logic [SW-1:0]   age_q;
	logic [ID_W-1:0] res_id_q;
	logic            res_hit_q;

	logic            accept;
	logic            issue;
	logic            match;
	logic            miss;
	logic            win;
	logic [ID_W-1:0] diff;
	logic [CW-1:0]   lim_c;
	logic [SW:0]     slot_sum;
	logic [SW:0]     slot_wrap;
	logic [SW-1:0]   rev_slot;
	logic [SW-1:0]   ws_inc;

	assign accept = in_valid && !in_stall;

	// the scan covers min(RING_DEPTH, counter - 1) ages; counter 0 means all
	always_comb begin
		if ((next_q > DEPTH_ID) || (next_q == '0)) begin
			lim_c = DEPTH_CNT;
		end else begin
			lim_c = next_q[CW-1:0] - CW'(1);
		end
	end

	assign issue = (state_q == ST_FWD_SCAN) && (cnt_q != limit_q);
	assign match = chk_v_s1 && (rd_data == id_q);
	assign miss  = (state_q == ST_FWD_SCAN) && !chk_v_s1 && !issue;

	assign diff = next_q - id_q;
	assign win  = (id_q != '0) && (id_q < next_q) && (diff < DEPTH_ID);

	// slot of an age: write slot - 1 - age, modulo the ring depth
	assign slot_sum  = {1'b0, ws_q} + (DEPTH_M1 - {1'b0, age_q});
	assign slot_wrap = (slot_sum >= DEPTH_X) ? slot_sum - DEPTH_X : slot_sum;
	assign rev_slot  = slot_wrap[SW-1:0];

	assign ws_inc = (ws_q == LAST_SLOT) ? '0 : ws_q + SW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		res_valid     = 1'b0;
		mem_ctl.rd_en = 1'b0;
		mem_ctl.wr_en = 1'b0;
		rd_addr       = ptr_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (req_type == REQ_REV) ? ST_REV_CHECK : ST_FWD_SCAN;
				end
			end
			ST_FWD_SCAN: begin
				mem_ctl.rd_en = issue;
				if (match) begin
					state_d = ST_DONE;
				end else if (miss) begin
					mem_ctl.wr_en = 1'b1;
					state_d       = ST_DONE;
				end
			end
			ST_REV_CHECK: begin
				state_d = win ? ST_REV_READ : ST_DONE;
			end
			ST_REV_READ: begin
				mem_ctl.rd_en = 1'b1;
				rd_addr       = rev_slot;
				state_d       = ST_REV_WAIT;
			end
			ST_REV_WAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// counter, write slot and scan pipeline valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q   <= ID_W'(1);
			ws_q     <= '0;
			chk_v_s1 <= 1'b0;
		end else begin
			chk_v_s1 <= issue && !match;
			if (miss) begin
				next_q <= next_q + ID_W'(1);
				ws_q   <= ws_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					id_q    <= frame_id;
					limit_q <= lim_c;
					cnt_q   <= '0;
					ptr_q   <= (ws_q == '0) ? LAST_SLOT : ws_q - SW'(1);
				end
			end
			ST_FWD_SCAN: begin
				if (issue) begin
					cnt_q  <= cnt_q + CW'(1);
					ptr_q  <= (ptr_q == '0) ? LAST_SLOT : ptr_q - SW'(1);
					age_s1 <= cnt_q[SW-1:0];
				end
				if (match) begin
					res_id_q  <= next_q - ID_W'(age_s1) - ID_W'(1);
					res_hit_q <= 1'b1;
				end else if (miss) begin
					res_id_q  <= next_q;
					res_hit_q <= 1'b0;
				end
			end
			ST_REV_CHECK: begin
				age_q <= diff[SW-1:0] - SW'(1);
				if (!win) begin
					res_id_q  <= '0;
					res_hit_q <= 1'b0;
				end
			end
			ST_REV_WAIT: begin
				res_id_q  <= rd_data;
				res_hit_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res_id  = res_id_q;
	assign res_hit = res_hit_q;
	assign wr_addr = ws_q;
	assign wr_data = id_q;

endmodule
`default_nettype wire

// ----- rtl/core/frame_id_translation_ring_core.sv -----
// Top level of the frame id translation ring: sequencer, ring memory, output register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------
//   in      | in_valid  | in_stall  | req_type, frame_id
//   out     | out_valid | out_stall | result_id, hit
//
// Forward request: one ring read per cycle over min(filled slots, RING_DEPTH)
//   entries; the single read port of the ring memory sets this rate. Reverse:
//   check, ring read and wait states inside the window, only the check state
//   outside it.
// The next item is taken the cycle after the output register loads.
// One item is in work at a time; the output register lets the next item be
//   taken while an earlier result still waits on out_stall.
// Reset: counter 1, write slot 0. Ring contents are not cleared; a slot is
//   read only once the counter says it has been written.
`default_nettype none
module frame_id_translation_ring_core
	import fitr_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            req_type,
	input  wire logic [ID_W-1:0] frame_id,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic      [ID_W-1:0] result_id,
	output logic                 hit
);

	localparam int SW = $clog2(RING_DEPTH);

	mem_ctl_t        mem_ctl;
	logic [SW-1:0]   rd_addr;
	logic [SW-1:0]   wr_addr;
	logic [ID_W-1:0] wr_data;
	logic [ID_W-1:0] rd_data;

	logic            res_valid;
	logic            res_ready;
	logic [ID_W-1:0] res_id;
	logic            res_hit;

	logic            out_valid_q;
	logic [ID_W-1:0] result_q;
	logic            hit_q;

	// Sequencer owns the counter and slot pointer; it issues all ring accesses.
	// A ring write (new assignment) and the next read of the same slot belong
	// to different items, so no read-after-write forwarding is needed.
	fitr_seq #(
		.RING_DEPTH(RING_DEPTH),
		.SW        (SW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.frame_id (frame_id),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_id   (res_id),
		.res_hit  (res_hit),
		.mem_ctl  (mem_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_data  (rd_data)
	);

	fitr_ring_mem #(
		.DEPTH(RING_DEPTH),
		.AW   (SW)
	) u_ring (
		.clk    (clk),
		.ctl    (mem_ctl),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	// output register: free when empty or being taken this cycle
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			result_q <= res_id;
			hit_q    <= res_hit;
		end
	end

	assign out_valid = out_valid_q;
	assign result_id = result_q;
	assign hit       = hit_q;

endmodule
`default_nettype wire

// ----- rtl/core/fitr_checker.sv -----
// Port-level checks for the frame id translation ring, bound to the top level.
`default_nettype none
module fitr_checker
	import fitr_pkg::*;
(
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_stall,
	input wire logic            req_type,
	input wire logic [ID_W-1:0] frame_id,
	input wire logic            out_valid,
	input wire logic            out_stall,
	input wire logic [ID_W-1:0] result_id,
	input wire logic            hit
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_id) && $stable(hit))
		else $error("stalled result changed");

	// one item in work: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	// a new result only ever follows a busy cycle
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	// device id 0 is never in the window
	a_rev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (req_type == REQ_REV) && (frame_id == '0) && !out_valid
		|-> ##3 (out_valid && !hit && (result_id == '0)))
		else $error("reverse lookup of id 0 did not miss");

endmodule

bind frame_id_translation_ring_core fitr_checker u_fitr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.req_type (req_type),
	.frame_id (frame_id),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.result_id(result_id),
	.hit      (hit)
);
`default_nettype wire
